@@ src/split_box_at_point_macros.svh @@
// Assertion helpers shared by the split_box_at_point RTL.
// Every macro samples on the rising edge of clock and is off while reset is high.
`ifndef SPLIT_BOX_AT_POINT_MACROS_SVH
`define SPLIT_BOX_AT_POINT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define SPB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define SPB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ src/spb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_pkg
// Shared types and constants of the octant box splitter.
// ----------------------------------------------------------------------------
package spb_pkg;

   localparam int COORD_BITS  = 32;
   localparam int NUM_OCTANTS = 8;
   localparam int OCT_BITS    = $clog2(NUM_OCTANTS);

   // Octant index bits: y half outermost, then x, then z (0 = near, 1 = far)
   localparam int OCT_Y_BIT = 2;
   localparam int OCT_X_BIT = 1;
   localparam int OCT_Z_BIT = 0;

   // Job queue between classifier and emitter; depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   // One classified item: the box, the point and the octants to emit
   typedef struct packed {
      vec_type                mn;
      vec_type                mx;
      vec_type                pt;
      logic [NUM_OCTANTS-1:0] keep;
      logic                   split;
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // One result item
   typedef struct packed {
      vec_type mn;
      vec_type mx;
      logic    box_valid;
      logic    was_split;
      logic    last;
   } rsp_type;

endpackage

@@ src/spb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_req_if / spb_rsp_if
// Valid/ready channels for the box-and-point items and the sub-box results.
// ----------------------------------------------------------------------------
interface spb_req_if;
   logic                valid;
   logic                ready;
   spb_pkg::coord_type  box_min_x;
   spb_pkg::coord_type  box_min_y;
   spb_pkg::coord_type  box_min_z;
   spb_pkg::coord_type  box_max_x;
   spb_pkg::coord_type  box_max_y;
   spb_pkg::coord_type  box_max_z;
   spb_pkg::coord_type  point_x;
   spb_pkg::coord_type  point_y;
   spb_pkg::coord_type  point_z;

   modport source (
      output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
             point_x, point_y, point_z,
      input  ready
   );
   modport sink (
      input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
             point_x, point_y, point_z,
      output ready
   );
endinterface

interface spb_rsp_if;
   logic                valid;
   logic                ready;
   spb_pkg::coord_type  out_min_x;
   spb_pkg::coord_type  out_min_y;
   spb_pkg::coord_type  out_min_z;
   spb_pkg::coord_type  out_max_x;
   spb_pkg::coord_type  out_max_y;
   spb_pkg::coord_type  out_max_z;
   logic                box_valid;
   logic                was_split;
   logic                last;

   modport source (
      output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
             box_valid, was_split, last,
      input  ready
   );
   modport sink (
      input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
             box_valid, was_split, last,
      output ready
   );
endinterface

@@ src/spb_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_fifo
// Short job queue between the classifier and the result emitter.
// ----------------------------------------------------------------------------
`include "split_box_at_point_macros.svh"

module spb_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  spb_pkg::job_type       push_job,
   input  logic                   pop,
   output spb_pkg::job_type       head,
   output spb_pkg::fifo_stat_type stat
);

   spb_pkg::job_type                 entries_ff [spb_pkg::QUEUE_DEPTH];
   logic [spb_pkg::PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [spb_pkg::PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [spb_pkg::CNT_BITS-1:0]     count_ff, count_in;

   // Report fill state and present the oldest job
   always_comb begin
      stat.full  = (count_ff == spb_pkg::CNT_BITS'(spb_pkg::QUEUE_DEPTH));
      stat.empty = (count_ff == '0);
      head       = entries_ff[rd_ptr_ff];
   end

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   `SPB_ASSERT_NOW(a_no_push_when_full, push, !stat.full)
   `SPB_ASSERT_NOW(a_no_pop_when_empty, pop, !stat.empty)
   `SPB_ASSERT_NOW(a_count_bound, 1'b1,
                   count_ff <= spb_pkg::CNT_BITS'(spb_pkg::QUEUE_DEPTH))

endmodule

@@ src/spb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_front
// Classify an incoming item: split or not, and which octants survive.
// ----------------------------------------------------------------------------
module spb_front (
   spb_req_if.sink                req_if,
   input  spb_pkg::fifo_stat_type stat,
   output logic                   push,
   output spb_pkg::job_type       push_job
);

   spb_pkg::coord_type     mn_x, mn_y, mn_z;
   spb_pkg::coord_type     mx_x, mx_y, mx_z;
   spb_pkg::coord_type     pt_x, pt_y, pt_z;
   logic                   outside;
   logic                   corner;
   logic                   split;
   logic [2:0]             near_ok;
   logic [2:0]             far_ok;
   logic [2:0]             oct;
   logic [spb_pkg::NUM_OCTANTS-1:0] keep;

   // Accept whenever the queue has room
   assign req_if.ready = !stat.full;
   assign push         = req_if.valid && !stat.full;

   always_comb begin
      mn_x = req_if.box_min_x;
      mn_y = req_if.box_min_y;
      mn_z = req_if.box_min_z;
      mx_x = req_if.box_max_x;
      mx_y = req_if.box_max_y;
      mx_z = req_if.box_max_z;
      pt_x = req_if.point_x;
      pt_y = req_if.point_y;
      pt_z = req_if.point_z;

      // Point outside the box (bounds inclusive) or on a corner: no split
      outside = (pt_x < mn_x) || (pt_x > mx_x) ||
                (pt_y < mn_y) || (pt_y > mx_y) ||
                (pt_z < mn_z) || (pt_z > mx_z);
      corner  = ((pt_x == mn_x) || (pt_x == mx_x)) &&
                ((pt_y == mn_y) || (pt_y == mx_y)) &&
                ((pt_z == mn_z) || (pt_z == mx_z));
      split   = !outside && !corner;

      // Per-axis half extents; index 0 = x, 1 = y, 2 = z
      near_ok = {pt_z != mn_z, pt_y != mn_y, pt_x != mn_x};
      far_ok  = {pt_z != mx_z, pt_y != mx_y, pt_x != mx_x};

      // Keep an octant only if none of its three halves is flat
      keep = '0;
      for (int k = 0; k < spb_pkg::NUM_OCTANTS; k++) begin
         oct     = 3'(k);
         keep[k] = split &&
                   (oct[spb_pkg::OCT_X_BIT] ? far_ok[0] : near_ok[0]) &&
                   (oct[spb_pkg::OCT_Y_BIT] ? far_ok[1] : near_ok[1]) &&
                   (oct[spb_pkg::OCT_Z_BIT] ? far_ok[2] : near_ok[2]);
      end

      push_job.mn    = '{x: mn_x, y: mn_y, z: mn_z};
      push_job.mx    = '{x: mx_x, y: mx_y, z: mx_z};
      push_job.pt    = '{x: pt_x, y: pt_y, z: pt_z};
      push_job.keep  = keep;
      push_job.split = split;
   end

endmodule

@@ src/spb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_back
// Walk the surviving octants of each job and emit one result item per cycle while rsp_if is not stalled.
// ----------------------------------------------------------------------------
`include "split_box_at_point_macros.svh"

module spb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  spb_pkg::job_type       head,
   input  spb_pkg::fifo_stat_type stat,
   output logic                   pop,
   spb_rsp_if.source              rsp_if
);

   spb_pkg::job_type                cur_ff, cur_in;
   logic [spb_pkg::NUM_OCTANTS-1:0] rem_ff, rem_in;
   logic                            busy_ff, busy_in;
   spb_pkg::rsp_type                rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   spb_pkg::job_type                job;
   logic [spb_pkg::NUM_OCTANTS-1:0] mask;
   logic [spb_pkg::NUM_OCTANTS-1:0] rem_left;
   logic [spb_pkg::OCT_BITS-1:0]    idx;
   logic                            out_free;
   logic                            fire;
   spb_pkg::rsp_type                res;

   // Pick the job being worked on: the held one, or the queue head
   always_comb begin
      job      = busy_ff ? cur_ff : head;
      mask     = busy_ff ? rem_ff : head.keep;
      out_free = !rsp_valid_ff || rsp_if.ready;
      fire     = (busy_ff || !stat.empty) && out_free;
      pop      = fire && !busy_ff;
      rem_left = mask & (mask - 1'b1);

      // Lowest pending octant
      idx = '0;
      for (int k = spb_pkg::NUM_OCTANTS - 1; k >= 0; k--) begin
         if (mask[k]) begin
            idx = spb_pkg::OCT_BITS'(k);
         end
      end
   end

   // Build the result item for the selected octant
   always_comb begin
      res = '0;
      if (mask == '0) begin
         res.was_split = job.split;
         res.last      = 1'b1;
      end else begin
         res.mn.x      = idx[spb_pkg::OCT_X_BIT] ? job.pt.x : job.mn.x;
         res.mx.x      = idx[spb_pkg::OCT_X_BIT] ? job.mx.x : job.pt.x;
         res.mn.y      = idx[spb_pkg::OCT_Y_BIT] ? job.pt.y : job.mn.y;
         res.mx.y      = idx[spb_pkg::OCT_Y_BIT] ? job.mx.y : job.pt.y;
         res.mn.z      = idx[spb_pkg::OCT_Z_BIT] ? job.pt.z : job.mn.z;
         res.mx.z      = idx[spb_pkg::OCT_Z_BIT] ? job.mx.z : job.pt.z;
         res.box_valid = 1'b1;
         res.was_split = 1'b1;
         res.last      = (rem_left == '0);
      end
   end

   // Advance the walk and the output register
   always_comb begin
      cur_in       = pop ? head : cur_ff;
      rem_in       = fire ? rem_left : rem_ff;
      busy_in      = fire ? (rem_left != '0) : busy_ff;
      rsp_in       = fire ? res : rsp_ff;
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   // Drive the result channel
   always_comb begin
      rsp_if.valid     = rsp_valid_ff;
      rsp_if.out_min_x = rsp_ff.mn.x;
      rsp_if.out_min_y = rsp_ff.mn.y;
      rsp_if.out_min_z = rsp_ff.mn.z;
      rsp_if.out_max_x = rsp_ff.mx.x;
      rsp_if.out_max_y = rsp_ff.mx.y;
      rsp_if.out_max_z = rsp_ff.mx.z;
      rsp_if.box_valid = rsp_ff.box_valid;
      rsp_if.was_split = rsp_ff.was_split;
      rsp_if.last      = rsp_ff.last;
   end

   `SPB_ASSERT_NOW(a_busy_has_work, busy_ff, rem_ff != '0)
   `SPB_ASSERT_NOW(a_box_implies_split, rsp_valid_ff && rsp_ff.box_valid, rsp_ff.was_split)
   `SPB_ASSERT_NOW(a_empty_result_is_last, rsp_valid_ff && !rsp_ff.box_valid, rsp_ff.last)
   `SPB_ASSERT_NEXT(a_pop_then_busy, pop && !res.last, busy_ff)

endmodule

@@ src/split_box_at_point.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_box_at_point
// Octant split of an axis-aligned box at a point, signed Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one item: box min/max corners and a split point.
//   rsp_if returns the results of that item in order: up to eight sub-boxes
//   (octants in y, x, z order, near half first), the final one marked last.
//   A point outside the box or on a corner gives one result with
//   was_split = 0; a split whose octants are all flat gives one result with
//   was_split = 1 and box_valid = 0; both carry zero coordinates.
// Timing:
//   An accepted item passes through the job queue and then the result
//   register before its first result shows on rsp_if.
//   The emitter produces one result per cycle while rsp_if is not stalled;
//   an item gives 1 to 8 results, and items follow with no gap.
//   A two-entry job queue decouples the classifier from the emitter, so
//   req_if stays ready while results are still being drained.
// Reset and stall:
//   Synchronous reset empties the queue and drops any pending result.
//   When rsp_if.ready is low the result register holds, the emitter stops,
//   and req_if.ready falls once the queue is full.
// ----------------------------------------------------------------------------
module split_box_at_point (
   input  logic      clock,
   input  logic      reset,
   spb_req_if.sink   req_if,
   spb_rsp_if.source rsp_if
);

   logic                   push;
   logic                   pop;
   spb_pkg::job_type       push_job;
   spb_pkg::job_type       head;
   spb_pkg::fifo_stat_type stat;

   // Classify incoming items
   spb_front u_front (
      .req_if   (req_if),
      .stat     (stat),
      .push     (push),
      .push_job (push_job)
   );

   // Hold classified jobs
   spb_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .stat     (stat)
   );

   // Emit result items
   spb_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .stat   (stat),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule
